@@ hdl/cpht_pkg.sv @@
`timescale 1ns / 1ps

package cpht_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int MIN_VERTICES = 3;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TEST = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS = 2'b01;
  localparam logic [1:0] SGN_NEG = 2'b10;

  typedef logic signed [COORD_W-1:0] coord_t;

  // read beat that travels alongside the ram read data
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } rd_beat_t;

  typedef struct packed {
    logic done;
    logic hit;
  } edge_res_t;

endpackage

@@ hdl/convex_polygon_hit_test.sv @@
`timescale 1ns / 1ps
// append and clear beats complete at acceptance; a test with n = min(vertex_count, 16) >= 3
// makes n + 1 vertex reads from the store's one read port, then passes the difference,
// product and sign stages before posting its result; with fewer than 3 vertices it posts a miss.
// one item is in flight at a time; the next is taken once the result reaches the output reg.
// synchronous reset empties the list, clears vertex_count and marks every entry as zero.
module convex_polygon_hit_test (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [4:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  cpht_pkg::coord_t           point_x,
  input  cpht_pkg::coord_t           point_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       inside_res
);
  import cpht_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_HOLD} state_t;

  state_t state;

  logic [4:0]              vertex_count;
  logic [CNT_W-1:0]        fill_count;
  logic [MAX_VERTICES-1:0] vbits;
  logic [CNT_W-1:0]        cnt_eff;
  logic [CNT_W-1:0]        test_cnt;
  logic [CNT_W-1:0]        idx;
  coord_t                  px;
  coord_t                  py;
  logic                    hold_res;

  logic                    accept;
  logic                    wr_en;
  logic [ADDR_W-1:0]       raddr;
  logic [2*COORD_W-1:0]    rdata;
  rd_beat_t                rd_beat;
  logic                    rd_ok;
  coord_t                  cur_x;
  coord_t                  cur_y;
  edge_res_t               edge_res;
  logic                    out_free;
  logic                    post_res;

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign wr_en = accept && (op == OP_APPEND) && (fill_count != CNT_W'(MAX_VERTICES));
  assign out_free = !out_valid || out_ready;
  assign post_res = out_free &&
                    (((state == ST_DRAIN) && edge_res.done) || (state == ST_HOLD));

  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      cnt_eff = CNT_W'(MAX_VERTICES);
    end else begin
      cnt_eff = CNT_W'(vertex_count);
    end
  end

  // the extra read past the last vertex wraps to vertex 0 for the closing edge
  assign raddr = (idx == test_cnt) ? '0 : idx[ADDR_W-1:0];

  cpht_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(fill_count[ADDR_W-1:0]),
    .wdata({point_x, point_y}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // never-written entries read as zero
  assign cur_x = rd_ok ? rdata[2*COORD_W-1:COORD_W] : '0;
  assign cur_y = rd_ok ? rdata[COORD_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_beat <= '0;
    end else begin
      rd_beat.vld <= (state == ST_RUN);
      rd_beat.first <= (idx == '0);
      rd_beat.last <= (idx == test_cnt);
    end
    rd_ok <= vbits[raddr];
  end

  cpht_edge u_edge (
    .clk     (clk),
    .rst     (rst),
    .rd_beat (rd_beat),
    .cur_x   (cur_x),
    .cur_y   (cur_y),
    .px      (px),
    .py      (py),
    .edge_res(edge_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      vbits <= '0;
    end else if (wr_en) begin
      fill_count <= fill_count + 1'b1;
      vbits[fill_count[ADDR_W-1:0]] <= 1'b1;
    end else if (accept && (op == OP_CLEAR)) begin
      fill_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
      test_cnt <= '0;
      hold_res <= 1'b0;
    end else begin
      if (post_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_TEST)) begin
            px <= point_x;
            py <= point_y;
            test_cnt <= cnt_eff;
            idx <= '0;
            if (cnt_eff < CNT_W'(MIN_VERTICES)) begin
              hold_res <= 1'b0;
              state <= ST_HOLD;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (idx == test_cnt) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (edge_res.done) begin
            if (out_free) begin
              inside_res <= edge_res.hit;
              state <= ST_IDLE;
            end else begin
              hold_res <= edge_res.hit;
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            inside_res <= hold_res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    edge_res.done |-> (state == ST_DRAIN))
    else $error("edge result outside drain");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_IDLE))
    else $error("store written during a test");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= 32'(MAX_VERTICES))
    else $error("fill count beyond list size");

  a_beat_from_run: assert property (@(posedge clk) disable iff (rst)
    rd_beat.vld |-> $past(state) == ST_RUN)
    else $error("read beat without a read");

endmodule

@@ hdl/cpht_ram.sv @@
`timescale 1ns / 1ps

module cpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cpht_edge.sv @@
`timescale 1ns / 1ps

module cpht_edge (
  input  logic               clk,
  input  logic               rst,
  input  cpht_pkg::rd_beat_t rd_beat,
  input  cpht_pkg::coord_t   cur_x,
  input  cpht_pkg::coord_t   cur_y,
  input  cpht_pkg::coord_t   px,
  input  cpht_pkg::coord_t   py,
  output cpht_pkg::edge_res_t edge_res
);
  import cpht_pkg::*;

  coord_t prev_x;
  coord_t prev_y;

  logic                     d_vld;
  logic                     d_last;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] qx;
  logic signed [DIFF_W-1:0] qy;

  logic                     p_vld;
  logic                     p_last;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;

  logic signed [PROD_W:0]   det;
  logic [1:0]               sgn;
  logic [1:0]               ref_sgn;
  logic                     fail;

  // stage 1: edge and point differences against the previous vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= rd_beat.vld && !rd_beat.first;
    end
    if (rd_beat.vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      dx <= {cur_x[COORD_W-1], cur_x} - {prev_x[COORD_W-1], prev_x};
      dy <= {cur_y[COORD_W-1], cur_y} - {prev_y[COORD_W-1], prev_y};
      qx <= {px[COORD_W-1], px} - {prev_x[COORD_W-1], prev_x};
      qy <= {py[COORD_W-1], py} - {prev_y[COORD_W-1], prev_y};
    end
    d_last <= rd_beat.last;
  end

  // stage 2: the two products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= d_vld;
    end
    p_last <= d_last;
    p1 <= dx * qy;
    p2 <= dy * qx;
  end

  assign det = {p1[PROD_W-1], p1} - {p2[PROD_W-1], p2};

  always_comb begin
    if (det[PROD_W]) begin
      sgn = SGN_NEG;
    end else if (det != '0) begin
      sgn = SGN_POS;
    end else begin
      sgn = SGN_ZERO;
    end
  end

  // stage 3: reference sign tracking, closing edge decides
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_sgn <= SGN_ZERO;
      fail <= 1'b0;
      edge_res.done <= 1'b0;
      edge_res.hit <= 1'b0;
    end else begin
      edge_res.done <= p_vld && p_last;
      if (p_vld) begin
        if (p_last) begin
          edge_res.hit <= !fail && (sgn == ref_sgn);
          ref_sgn <= SGN_ZERO;
          fail <= 1'b0;
        end else if (ref_sgn == SGN_ZERO) begin
          ref_sgn <= sgn;
        end else if (sgn != ref_sgn) begin
          fail <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sim/tb_convex_polygon_hit_test.sv @@
`timescale 1ns / 1ps

module tb_convex_polygon_hit_test;
  import cpht_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PHASES = 30;
  localparam int ITEMS_PER_PHASE = 48;

  typedef struct packed {
    logic [1:0] op;
    coord_t     x;
    coord_t     y;
  } hit_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = '0;
  coord_t     point_x = '0;
  coord_t     point_y = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       inside_res;

  // shadow of the vertex store and the count register
  coord_t     poly_x[MAX_VERTICES] = '{default: '0};
  coord_t     poly_y[MAX_VERTICES] = '{default: '0};
  int         poly_fill = 0;
  logic [4:0] poly_count = '0;

  hit_beat_t  pending_beats[$];
  bit         expected_inside[$];
  hit_beat_t  drv_beat;
  bit         expected_bit;
  int         error_count = 0;
  int         cycle_count = 0;
  bit         in_gaps_on = 1'b0;
  bit         out_stalls_on = 1'b0;
  int         in_gap_left = 0;
  int         out_stall_left = 0;

  convex_polygon_hit_test dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int saturate16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // sign of (b - a) x (p - a), exact in 64 bits
  function automatic int edge_turn(int a, int b, coord_t px, coord_t py);
    longint ax, ay, bx, by, d;
    ax = poly_x[a];
    ay = poly_y[a];
    bx = poly_x[b];
    by = poly_y[b];
    d = (bx - ax) * (longint'(py) - ay) - (by - ay) * (longint'(px) - ax);
    if (d < 0) return -1;
    if (d > 0) return 1;
    return 0;
  endfunction

  function automatic bit poly_contains(coord_t px, coord_t py);
    int cnt, ref_sgn, s, n;
    cnt = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    if (cnt < MIN_VERTICES) return 1'b0;
    ref_sgn = 0;
    for (n = 0; n + 1 < cnt; n++) begin
      s = edge_turn(n, n + 1, px, py);
      if (ref_sgn == 0) ref_sgn = s;
      else if (s != ref_sgn) return 1'b0;
    end
    // closing edge must agree with the reference, even a zero one
    return edge_turn(cnt - 1, 0, px, py) == ref_sgn;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (drv_beat.op)
          OP_APPEND: begin
            if (poly_fill < MAX_VERTICES) begin
              poly_x[poly_fill] = drv_beat.x;
              poly_y[poly_fill] = drv_beat.y;
              poly_fill++;
            end
          end
          OP_TEST: expected_inside.push_back(poly_contains(drv_beat.x, drv_beat.y));
          OP_CLEAR: poly_fill = 0;
          default: ;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          drv_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          op <= drv_beat.op;
          point_x <= drv_beat.x;
          point_y <= drv_beat.y;
          in_gap_left = in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_inside.size() == 0) begin
          $error("inside_res: unexpected result beat, expected none, actual %0d", inside_res);
          error_count++;
        end else begin
          expected_bit = expected_inside.pop_front();
          if (inside_res !== expected_bit) begin
            $error("inside_res mismatch: expected %0d, actual %0d", expected_bit, inside_res);
            error_count++;
          end
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 3) == 0) out_stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_beat(input logic [1:0] code, input int x, input int y);
    hit_beat_t b;
    b.op = code;
    b.x = x[15:0];
    b.y = y[15:0];
    pending_beats.push_back(b);
  endtask

  // sampled at the falling edge so the check never races the posedge updates
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_inside.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [4:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    poly_count = v;
    in_gaps_on = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
    @(negedge clk);
  endtask

  // clear, append a convex polygon (sometimes too few or too many vertices), then mostly tests around it
  task automatic random_phase();
    int cnt, n_poly, n_app, cx, cy, rad, sel, k, j, px, py;
    int vx_gen[20];
    int vy_gen[20];
    real base, step, ang;
    bit flip;
    sel = $urandom_range(0, 9);
    if (sel == 0) cnt = $urandom_range(0, 2);
    else if (sel == 1) cnt = $urandom_range(17, 31);
    else cnt = $urandom_range(3, 16);
    set_vertex_count(cnt[4:0]);
    n_poly = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
    n_app = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 20) : n_poly;
    sel = $urandom_range(0, 9);
    if (sel < 2) rad = $urandom_range(1, 64);
    else if (sel == 9) rad = 32767;
    else rad = $urandom_range(65, 16000);
    cx = (rad == 32767) ? 0 : int'($urandom_range(0, 32000)) - 16000;
    cy = (rad == 32767) ? 0 : int'($urandom_range(0, 32000)) - 16000;
    base = $urandom_range(0, 6283) / 1000.0;
    flip = $urandom_range(0, 1);
    step = 6.283185307 / ((n_poly > 0) ? n_poly : 1);
    for (k = 0; k < 20; k++) begin
      if (k < n_poly) begin
        // jitter stays inside each slot so the angles remain sorted
        ang = base + step * (k + 0.8 * $urandom_range(0, 999) / 1000.0);
        if (flip) ang = -ang;
        vx_gen[k] = saturate16(cx + $rtoi(rad * $cos(ang)));
        vy_gen[k] = saturate16(cy + $rtoi(rad * $sin(ang)));
      end else begin
        vx_gen[k] = rand_coord();
        vy_gen[k] = rand_coord();
      end
    end
    push_beat(OP_CLEAR, rand_coord(), rand_coord());
    for (k = 0; k < n_app; k++) push_beat(OP_APPEND, vx_gen[k], vy_gen[k]);
    for (k = 0; k < ITEMS_PER_PHASE; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 14) begin
        push_beat(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          px = cx + int'($urandom_range(0, rad)) - rad / 2;
          py = cy + int'($urandom_range(0, rad)) - rad / 2;
        end else if (sel < 70) begin
          px = cx + int'($urandom_range(0, 2 * rad + 16)) - rad - 8;
          py = cy + int'($urandom_range(0, 2 * rad + 16)) - rad - 8;
        end else if (sel < 88 && n_poly > 0) begin
          j = $urandom_range(0, n_poly - 1);
          if (sel < 80) begin
            px = vx_gen[j];
            py = vy_gen[j];
          end else begin
            px = (vx_gen[j] + vx_gen[(j + 1) % n_poly]) / 2;
            py = (vy_gen[j] + vy_gen[(j + 1) % n_poly]) / 2;
          end
        end else begin
          px = rand_coord();
          py = rand_coord();
        end
        push_beat(OP_TEST, saturate16(px), saturate16(py));
      end
    end
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // too few vertices, and the unused op
    set_vertex_count(5'd0);
    push_beat(OP_TEST, 0, 0);
    push_beat(OP_UNUSED, -1, -1);

    // all-zero store: every edge product is zero, so the point counts as inside
    set_vertex_count(5'd16);
    push_beat(OP_TEST, 0, 0);
    push_beat(OP_TEST, 32767, -32768);

    // full-range square
    set_vertex_count(5'd4);
    push_beat(OP_APPEND, -32768, -32768);
    push_beat(OP_APPEND, 32767, -32768);
    push_beat(OP_APPEND, 32767, 32767);
    push_beat(OP_APPEND, -32768, 32767);
    push_beat(OP_TEST, 0, 0);
    push_beat(OP_TEST, -32768, -32768);
    push_beat(OP_TEST, 32767, 0);
    push_beat(OP_TEST, -32767, 32766);

    // count above the store depth, then below three
    set_vertex_count(5'd31);
    push_beat(OP_TEST, 0, 0);
    push_beat(OP_TEST, 100, -5);
    set_vertex_count(5'd2);
    push_beat(OP_TEST, 1, 1);

    // clear and reuse with a small triangle
    set_vertex_count(5'd3);
    push_beat(OP_CLEAR, 0, 0);
    push_beat(OP_APPEND, 10, 0);
    push_beat(OP_APPEND, 0, 10);
    push_beat(OP_APPEND, -10, -10);
    push_beat(OP_TEST, 0, 0);
    push_beat(OP_TEST, 20, 20);
    push_beat(OP_TEST, 5, 5);

    for (p = 0; p < RANDOM_PHASES; p++) random_phase();

    wait_drained();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
